// File: rtl/core/thcirc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thick circle generator package
// Widths, algorithm constants, register indexes and the point record shared
// by the stepper and the top level.
// ----------------------------------------------------------------------------
package thcirc_pkg;

  // Field widths
  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 11;
  localparam int COLOR_BITS  = 32;
  localparam int RINGS_BITS  = 6;
  localparam int CENTER_BITS = COORD_BITS + 1;   // signed command center
  localparam int PIX_BITS    = COORD_BITS + 2;   // signed generated point
  localparam int CFG_BITS    = 13;               // config register width
  localparam int CFG_IDX_BITS = 2;
  localparam int DEC_BITS    = 16;               // midpoint decision term
  localparam int OFFSET_BITS = 24;
  localparam int OCT_BITS    = 3;

  // Midpoint circle constants
  localparam int DEC_INIT     = 3;   // d0 = 3 - 2r
  localparam int DEC_STEP_NEG = 6;   // d += 4x + 6
  localparam int DEC_STEP_POS = 10;  // d += 4(x - y) + 10

  // Last octant of one step
  localparam logic [OCT_BITS-1:0] OCT_LAST = OCT_BITS'(7);

  // Config register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_PITCH    = CFG_IDX_BITS'(2);

  // Config reset values
  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(1024);
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(768);
  localparam logic [CFG_BITS-1:0] PITCH_RESET  = CFG_BITS'(1024);

  // One generated point before clipping
  typedef struct packed {
    logic signed [PIX_BITS-1:0] x;
    logic signed [PIX_BITS-1:0] y;
    logic [COLOR_BITS-1:0]      color;
    logic                       last;
  } point_t;

endpackage

// File: rtl/core/thcirc_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thick circle stepper
// Holds the command and midpoint state, presents the current point and
// advances one octant point per advance request.
// ----------------------------------------------------------------------------
module thcirc_stepper (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic                                  advance,
  input  logic signed [thcirc_pkg::CENTER_BITS-1:0] center_x,
  input  logic signed [thcirc_pkg::CENTER_BITS-1:0] center_y,
  input  logic [thcirc_pkg::RADIUS_BITS-1:0]    radius,
  input  logic [thcirc_pkg::RINGS_BITS-1:0]     ring_count,
  input  logic [thcirc_pkg::COLOR_BITS-1:0]     color,
  output logic                                  busy,
  output thcirc_pkg::point_t                    point
);
  import thcirc_pkg::*;

  logic signed [CENTER_BITS-1:0] center_col;
  logic signed [CENTER_BITS-1:0] center_row;
  logic [RADIUS_BITS-1:0]        ring_radius;
  logic [RINGS_BITS-1:0]         rings_left;
  logic [RADIUS_BITS-1:0]        step_x;
  logic [RADIUS_BITS-1:0]        step_y;
  logic signed [DEC_BITS-1:0]    decision;
  logic [OCT_BITS-1:0]           octant_index;
  logic [COLOR_BITS-1:0]         color_hold;

  logic [RADIUS_BITS-1:0]        a_mag, b_mag;
  logic signed [PIX_BITS-1:0]    a_off, b_off;
  logic [RADIUS_BITS-1:0]        step_x_next, step_y_next;
  logic signed [RADIUS_BITS:0]   diff;
  logic signed [DEC_BITS-1:0]    decision_next;
  logic [RADIUS_BITS-1:0]        radius_dec;
  logic [RINGS_BITS-1:0]         rings_dec;
  logic                          ring_done;
  logic                          cmd_done;

  // Octant selection: bit 2 swaps x/y, bit 0 negates a, bit 1 negates b
  always_comb begin
    a_mag = octant_index[2] ? step_y : step_x;
    b_mag = octant_index[2] ? step_x : step_y;
    a_off = $signed({{(PIX_BITS-RADIUS_BITS){1'b0}}, a_mag});
    b_off = $signed({{(PIX_BITS-RADIUS_BITS){1'b0}}, b_mag});
    if (octant_index[0]) begin
      a_off = -a_off;
    end
    if (octant_index[1]) begin
      b_off = -b_off;
    end
  end

  // Midpoint step update, used after the eighth point
  always_comb begin
    diff = $signed({1'b0, step_x}) - $signed({1'b0, step_y});
    step_x_next = step_x + RADIUS_BITS'(1);
    if (decision < 0) begin
      decision_next = decision
                    + $signed({{(DEC_BITS-RADIUS_BITS-2){1'b0}}, step_x, 2'b00})
                    + DEC_BITS'(DEC_STEP_NEG);
      step_y_next   = step_y;
    end else begin
      decision_next = decision
                    + $signed({{(DEC_BITS-RADIUS_BITS-3){diff[RADIUS_BITS]}}, diff, 2'b00})
                    + DEC_BITS'(DEC_STEP_POS);
      step_y_next   = step_y - RADIUS_BITS'(1);
    end
    ring_done  = step_x_next > step_y_next;
    radius_dec = ring_radius - RADIUS_BITS'(1);
    rings_dec  = rings_left - RINGS_BITS'(1);
    cmd_done   = ring_done && ((rings_dec == '0) || (radius_dec == '0));
  end

  // Current point
  always_comb begin
    point.x     = PIX_BITS'(center_col) + a_off;
    point.y     = PIX_BITS'(center_row) + b_off;
    point.color = color_hold;
    point.last  = (octant_index == OCT_LAST) && cmd_done;
  end

  // Command and step state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      center_col   <= '0;
      center_row   <= '0;
      ring_radius  <= '0;
      rings_left   <= '0;
      step_x       <= '0;
      step_y       <= '0;
      decision     <= '0;
      octant_index <= '0;
      color_hold   <= '0;
    end else if (start) begin
      busy         <= (radius != '0) && (ring_count != '0);
      center_col   <= center_x;
      center_row   <= center_y;
      ring_radius  <= radius;
      rings_left   <= ring_count;
      color_hold   <= color;
      step_x       <= '0;
      step_y       <= radius;
      decision     <= DEC_BITS'(DEC_INIT)
                    - $signed({{(DEC_BITS-RADIUS_BITS-1){1'b0}}, radius, 1'b0});
      octant_index <= '0;
    end else if (advance && busy) begin
      if (octant_index != OCT_LAST) begin
        octant_index <= octant_index + OCT_BITS'(1);
      end else begin
        octant_index <= '0;
        if (ring_done && !cmd_done) begin
          // next ring inward
          ring_radius <= radius_dec;
          rings_left  <= rings_dec;
          step_x      <= '0;
          step_y      <= radius_dec;
          decision    <= DEC_BITS'(DEC_INIT)
                       - $signed({{(DEC_BITS-RADIUS_BITS-1){1'b0}}, radius_dec, 1'b0});
        end else begin
          step_x   <= step_x_next;
          step_y   <= step_y_next;
          decision <= decision_next;
          if (ring_done) begin
            ring_radius <= radius_dec;
            rings_left  <= rings_dec;
            busy        <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/thick_circle_pixel_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thick circle pixel generator
// Midpoint circle rasterizer drawing concentric rings, one point per advance request.
// ----------------------------------------------------------------------------
// A start request (mode 0) loads center, radius, ring count and color and
// yields no pixel; an advance request (mode 1) yields the next point of the
// command, with clip flag, linear offset y*pitch+x and a last flag on the
// final point. An advance while no command is active yields nothing. The
// block takes one request per clock unless the pixel channel stalls: the
// midpoint state updates on each accepted request, the point goes to a
// point register and then through the clip and the 13x13 offset multiply
// into the output register. Output stalls back up through these two stages.
// The user must write configuration only while the block is idle; the
// block itself does not enforce this.
module thick_circle_pixel_generator (
  input  logic                                     clk,
  input  logic                                     rst,
  // configuration
  input  logic                                     cfg_write,
  input  logic [thcirc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [thcirc_pkg::CFG_BITS-1:0]          cfg_data,
  // request channel
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     mode,
  input  logic signed [thcirc_pkg::CENTER_BITS-1:0] center_x,
  input  logic signed [thcirc_pkg::CENTER_BITS-1:0] center_y,
  input  logic [thcirc_pkg::RADIUS_BITS-1:0]       radius,
  input  logic [thcirc_pkg::RINGS_BITS-1:0]        ring_count,
  input  logic [thcirc_pkg::COLOR_BITS-1:0]        color,
  // pixel channel
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [thcirc_pkg::PIX_BITS-1:0]   pixel_x,
  output logic signed [thcirc_pkg::PIX_BITS-1:0]   pixel_y,
  output logic                                     on_screen,
  output logic [thcirc_pkg::OFFSET_BITS-1:0]       pixel_offset,
  output logic [thcirc_pkg::COLOR_BITS-1:0]        pixel_color,
  output logic                                     last
);
  import thcirc_pkg::*;

  logic [CFG_BITS-1:0] screen_width;
  logic [CFG_BITS-1:0] screen_height;
  logic [CFG_BITS-1:0] line_pitch;

  logic   in_fire;
  logic   start;
  logic   advance;
  logic   busy;
  point_t step_point;

  logic   pt_valid;
  point_t pt;
  logic   out_load;
  logic   pt_load;

  logic                        clip_on;
  logic [2*CFG_BITS-1:0]       row_base;
  logic [OFFSET_BITS-1:0]      offset_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
      line_pitch    <= PITCH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        REG_LINE_PITCH:    line_pitch    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake and pipeline flow
  assign out_load = !out_valid || out_ready;
  assign pt_load  = !pt_valid || out_load;
  assign in_ready = pt_load;
  assign in_fire  = in_valid && in_ready;
  assign start    = in_fire && !mode;
  assign advance  = in_fire && mode;

  thcirc_stepper u_stepper (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .advance    (advance),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius     (radius),
    .ring_count (ring_count),
    .color      (color),
    .busy       (busy),
    .point      (step_point)
  );

  // Point register
  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else if (pt_load) begin
      pt_valid <= advance && busy;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_load) begin
      pt <= step_point;
    end
  end

  // Clip and linear offset
  always_comb begin
    clip_on = !pt.x[PIX_BITS-1] && !pt.y[PIX_BITS-1]
           && (pt.x[CFG_BITS-1:0] < screen_width)
           && (pt.y[CFG_BITS-1:0] < screen_height);
    row_base = pt.y[CFG_BITS-1:0] * line_pitch;
    offset_next = '0;
    if (clip_on) begin
      offset_next = row_base[OFFSET_BITS-1:0]
                  + {{(OFFSET_BITS-CFG_BITS){1'b0}}, pt.x[CFG_BITS-1:0]};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_x      <= pt.x;
      pixel_y      <= pt.y;
      on_screen    <= clip_on;
      pixel_offset <= offset_next;
      pixel_color  <= pt.color;
      last         <= pt.last;
    end
  end

`ifndef SYNTH
  // A start leaves the stepper busy exactly when the command draws something
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy == $past((radius != '0) && (ring_count != '0)))
    else $error("busy does not follow start command");

  // The final point of a command ends it
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && busy && step_point.last) |=> !busy)
    else $error("stepper still busy after last point");

  // Off-screen pixels carry a zero offset
  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !on_screen) |-> (pixel_offset == '0))
    else $error("offset nonzero for off-screen pixel");
`endif

endmodule

// File: tb/thick_circle_pixel_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thick circle pixel generator testbench
// Drives start and advance requests with random source gaps and sink stalls.
// A behavioral midpoint-circle rasterizer predicts every pixel (coordinates,
// clip flag, linear offset, color, last flag). Each returned pixel is compared
// with the oldest prediction. The screen registers are swept through zero,
// one, 4096, the 13-bit maximum and random sizes, always while idle.
// ----------------------------------------------------------------------------
module thick_circle_pixel_generator_tb;
  import thcirc_pkg::*;

  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;
  // index past the register list, must be ignored
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = CFG_IDX_BITS'(3);
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;     // two-stage output pipe plus margin

  typedef struct {
    logic signed [PIX_BITS-1:0] x;
    logic signed [PIX_BITS-1:0] y;
    logic                       visible;
    logic [OFFSET_BITS-1:0]     offset;
    logic [COLOR_BITS-1:0]      color;
    logic                       last;
  } pixel_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [CFG_IDX_BITS-1:0]       cfg_index;
  logic [CFG_BITS-1:0]           cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic                          mode;
  logic signed [CENTER_BITS-1:0] center_x;
  logic signed [CENTER_BITS-1:0] center_y;
  logic [RADIUS_BITS-1:0]        radius;
  logic [RINGS_BITS-1:0]         ring_count;
  logic [COLOR_BITS-1:0]         color;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [PIX_BITS-1:0]    pixel_x;
  logic signed [PIX_BITS-1:0]    pixel_y;
  logic                          on_screen;
  logic [OFFSET_BITS-1:0]        pixel_offset;
  logic [COLOR_BITS-1:0]         pixel_color;
  logic                          last;

  thick_circle_pixel_generator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius      (radius),
    .ring_count  (ring_count),
    .color       (color),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .on_screen   (on_screen),
    .pixel_offset(pixel_offset),
    .pixel_color (pixel_color),
    .last        (last)
  );

  // Rasterizer state and register shadow
  bit                     circ_busy;
  int                     circ_cx, circ_cy;
  int                     circ_radius, circ_rings;
  logic [COLOR_BITS-1:0]  circ_color;
  int                     walk_x, walk_y, walk_err;
  logic [OCT_BITS-1:0]    walk_oct;
  int                     scr_width, scr_height, scr_pitch;

  pixel_t pending_pixels[$];
  bit     pacing_on;
  int     n_errors, n_sent, n_starts, n_pixels, n_visible, n_last, n_wraps;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Load the current ring's midpoint walk
  function automatic void restart_ring();
    walk_x   = 0;
    walk_y   = circ_radius;
    walk_err = DEC_INIT - 2 * circ_radius;
    walk_oct = '0;
  endfunction

  // Apply one accepted request to the rasterizer, queue the pixel it yields
  function automatic void rasterize_request(input logic md,
      input logic signed [CENTER_BITS-1:0] cx, input logic signed [CENTER_BITS-1:0] cy,
      input logic [RADIUS_BITS-1:0] r, input logic [RINGS_BITS-1:0] rc,
      input logic [COLOR_BITS-1:0] colr);
    pixel_t     pix;
    int         a, b, px, py;
    logic [63:0] lin;
    if (md == MODE_START) begin
      circ_cx     = cx;
      circ_cy     = cy;
      circ_radius = r;
      circ_rings  = rc;
      circ_color  = colr;
      circ_busy   = (r != 0) && (rc != 0);
      restart_ring();
      n_starts++;
      return;
    end
    if (!circ_busy) return;

    // octants 4..7 swap the roles of x and y
    a  = walk_oct[2] ? walk_y : walk_x;
    b  = walk_oct[2] ? walk_x : walk_y;
    px = circ_cx + (walk_oct[0] ? -a : a);
    py = circ_cy + (walk_oct[1] ? -b : b);

    pix.x       = px[PIX_BITS-1:0];
    pix.y       = py[PIX_BITS-1:0];
    pix.visible = (px >= 0) && (py >= 0) && (px < scr_width) && (py < scr_height);
    lin = '0;
    if (pix.visible) begin
      lin = longint'(py) * longint'(scr_pitch) + longint'(px);
      if (lin >= 64'd16777216) n_wraps++;
    end
    pix.offset = lin[OFFSET_BITS-1:0];
    pix.color  = circ_color;
    pix.last   = 1'b0;

    // step the midpoint walk after the eighth point
    if (walk_oct != OCT_LAST) begin
      walk_oct++;
    end else begin
      if (walk_err < 0) begin
        walk_err += 4 * walk_x + DEC_STEP_NEG;
      end else begin
        walk_err += 4 * (walk_x - walk_y) + DEC_STEP_POS;
        walk_y--;
      end
      walk_x++;
      walk_oct = '0;
      if (walk_x > walk_y) begin
        circ_radius--;
        circ_rings--;
        if (circ_rings == 0 || circ_radius == 0) begin
          circ_busy = 1'b0;
          pix.last  = 1'b1;
        end else begin
          restart_ring();
        end
      end
    end
    pending_pixels.push_back(pix);
  endfunction

  // Center coordinate mostly near the visible area, sometimes anywhere
  function automatic logic signed [CENTER_BITS-1:0] pick_coord(input int extent);
    int lim;
    if ($urandom_range(0, 7) == 0) return CENTER_BITS'($urandom);
    lim = (extent > 4063) ? 4111 : extent + 32;
    return CENTER_BITS'($urandom_range(0, lim) - 16);
  endfunction

  // Send one request; predict on acceptance
  task automatic send_request(input logic md,
      input logic signed [CENTER_BITS-1:0] cx, input logic signed [CENTER_BITS-1:0] cy,
      input logic [RADIUS_BITS-1:0] r, input logic [RINGS_BITS-1:0] rc,
      input logic [COLOR_BITS-1:0] colr);
    if (pacing_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= md;
    center_x   <= cx;
    center_y   <= cy;
    radius     <= r;
    ring_count <= rc;
    color      <= colr;
    do @(posedge clk); while (!in_ready);
    rasterize_request(md, cx, cy, r, rc, colr);
    n_sent++;
  endtask

  task automatic start_cmd(input logic signed [CENTER_BITS-1:0] cx,
      input logic signed [CENTER_BITS-1:0] cy, input logic [RADIUS_BITS-1:0] r,
      input logic [RINGS_BITS-1:0] rc, input logic [COLOR_BITS-1:0] colr);
    send_request(MODE_START, cx, cy, r, rc, colr);
  endtask

  // Advance fields are don't-care, so fill them with noise
  task automatic advance();
    send_request(MODE_ADVANCE, CENTER_BITS'($urandom), CENTER_BITS'($urandom),
                 RADIUS_BITS'($urandom), RINGS_BITS'($urandom), $urandom);
  endtask

  // Stop sending and let every predicted pixel come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Program the screen registers while idle, plus a write that must be ignored
  task automatic apply_screen(input int w, input int h, input int p);
    if (circ_busy) start_cmd(0, 0, 0, 0, 0);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= CFG_BITS'(w);
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data  <= CFG_BITS'(h);
    @(posedge clk);
    cfg_index <= REG_LINE_PITCH;
    cfg_data  <= CFG_BITS'(p);
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= CFG_BITS'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
    scr_width  = w;
    scr_height = h;
    scr_pitch  = p;
  endtask

  // Random command mix: mostly full commands, some cut short, some noise
  task automatic run_commands(input int n_items);
    int stop_at, cap, kind, r, rc;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        r  = $urandom_range(1, 8);
        rc = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(1, r + 1);
        start_cmd(pick_coord(scr_width), pick_coord(scr_height), RADIUS_BITS'(r),
                  RINGS_BITS'(rc), $urandom);
        cap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : 100000;
        while (circ_busy && cap > 0) begin
          advance();
          cap--;
        end
        if ($urandom_range(0, 7) == 0) advance();
      end else if (kind == 7) begin
        // wide radius: only the first points are walked
        start_cmd(pick_coord(scr_width), pick_coord(scr_height),
                  RADIUS_BITS'($urandom_range(0, 2047)), RINGS_BITS'($urandom_range(0, 63)),
                  $urandom);
        repeat ($urandom_range(0, 30)) advance();
      end else if ($urandom_range(0, 1) == 0) begin
        advance();
      end else if ($urandom_range(0, 1) == 0) begin
        start_cmd(pick_coord(scr_width), pick_coord(scr_height), 0, RINGS_BITS'($urandom),
                  $urandom);
      end else begin
        start_cmd(pick_coord(scr_width), pick_coord(scr_height), RADIUS_BITS'($urandom), 0,
                  $urandom);
      end
    end
  endtask

  // Idle advance, then empty commands of both kinds
  task automatic test_idle_requests();
    advance();
    start_cmd(100, 100, 0, 5, 32'h1234_5678);
    advance();
    start_cmd(100, 100, 5, 0, 32'h8765_4321);
    advance();
  endtask

  // Radius 2 with many rings: second ring starts, radius runs down to zero
  task automatic test_two_ring_command();
    start_cmd(0, 0, 2, 63, 32'hA5A5_5A5A);
    while (circ_busy) advance();
    advance();
  endtask

  // Extreme centers, radius and ring count; each start cuts the previous one
  task automatic test_extreme_commands();
    start_cmd(-4096, 4095, 2047, 63, 32'hFFFF_FFFF);
    repeat (3) advance();
    start_cmd(4095, -4096, 2047, 63, 32'h0000_0000);
    repeat (3) advance();
  endtask

  // Clip and offset under boundary and random screen settings
  task automatic test_screen_settings();
    apply_screen(0, 768, 1024);
    run_commands(200);
    apply_screen(1024, 0, 0);
    run_commands(200);
    apply_screen(1, 1, 1);
    run_commands(150);
    apply_screen(4096, 4096, 4096);
    run_commands(200);
    apply_screen(8191, 8191, 8191);
    run_commands(200);
    repeat (2) begin
      apply_screen($urandom_range(1, 8191), $urandom_range(1, 8191), $urandom_range(1, 8191));
      run_commands(200);
    end
  endtask

  // Back to reset sizes with no gaps or stalls on either side
  task automatic test_unpaced_run();
    apply_screen(int'(WIDTH_RESET), int'(HEIGHT_RESET), int'(PITCH_RESET));
    pacing_on = 1'b0;
    run_commands(250);
  endtask

  task automatic check_field(input string name, input logic signed [40:0] want,
                             input logic signed [40:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Compare each returned pixel with the oldest prediction
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d", pixel_x, pixel_y);
        n_errors++;
      end else begin
        want = pending_pixels.pop_front();
        n_pixels++;
        if (want.visible) n_visible++;
        if (want.last) n_last++;
        check_field("pixel_x", want.x, pixel_x);
        check_field("pixel_y", want.y, pixel_y);
        check_field("on_screen", want.visible, on_screen);
        check_field("pixel_offset", want.offset, pixel_offset);
        check_field("pixel_color", want.color, pixel_color);
        check_field("last", want.last, last);
      end
    end
  end

  // Sink stalls in random bursts
  initial begin : sink_pacing
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (pacing_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any request or pixel moving
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles, %0d pixels outstanding",
                 idle_cycles, pending_pixels.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Test sequence
  initial begin
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_index  <= REG_SCREEN_WIDTH;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    mode       <= MODE_ADVANCE;
    center_x   <= '0;
    center_y   <= '0;
    radius     <= '0;
    ring_count <= '0;
    color      <= '0;
    pacing_on  = 1'b1;
    scr_width  = int'(WIDTH_RESET);
    scr_height = int'(HEIGHT_RESET);
    scr_pitch  = int'(PITCH_RESET);
    circ_busy  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_idle_requests();
    test_two_ring_command();
    test_extreme_commands();
    test_screen_settings();
    test_unpaced_run();
    wait_idle();

    $display("Sent %0d requests (%0d starts); checked %0d pixels, %0d on screen, %0d last.",
             n_sent, n_starts, n_pixels, n_visible, n_last);
    $display("Screen sizes zero, one, 4096, 8191 and random; %0d offsets wrapped.", n_wraps);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
